// ===== design/urt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the fragment reassembly tracker.
// No dependencies; every other file of the block imports this package.
package urt_pkg;

    localparam int STAMP_W      = 64;
    localparam int FIELD_W      = 32;
    localparam int LEN_W        = 16;
    localparam int OFFSET_W     = 22;
    localparam int STATUS_W     = 2;
    localparam int HEADER_BYTES = 20;

    localparam logic [LEN_W-1:0] SLOT_RESET = 16'd1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW   = 2'd0,
        ST_DUP   = 2'd1,
        ST_LEN   = 2'd2,
        ST_RANGE = 2'd3
    } urt_status_t;

    // Header checks passed from the classifier to the tracker
    typedef struct packed {
        logic length_bad;
        logic range_bad;
    } urt_check_t;

endpackage

// ===== design/urt_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the tracker: fragment headers, results, configuration.
// Depends on urt_pkg for field widths.
interface urt_frag_if;
    import urt_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAMP_W-1:0] frame_stamp;
    logic [FIELD_W-1:0] frag_index;
    logic [FIELD_W-1:0] frag_count;
    logic [LEN_W-1:0]   body_bytes;
    logic [LEN_W-1:0]   datagram_bytes;

    modport source (output valid, frame_stamp, frag_index, frag_count, body_bytes,
                    datagram_bytes, input ready);
    modport sink   (input valid, frame_stamp, frag_index, frag_count, body_bytes,
                    datagram_bytes, output ready);
endinterface

interface urt_result_if;
    import urt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] write_offset;
    logic [LEN_W-1:0]    write_bytes;
    logic                frame_done;
    logic [OFFSET_W-1:0] frame_length;
    logic [STAMP_W-1:0]  done_stamp;

    modport source (output valid, status, write_offset, write_bytes, frame_done,
                    frame_length, done_stamp, input ready);
    modport sink   (input valid, status, write_offset, write_bytes, frame_done,
                    frame_length, done_stamp, output ready);
endinterface

interface urt_cfg_if;
    import urt_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/urt_classify.sv =====
`timescale 1ns / 1ps
// Header checks and slot offset for one registered fragment header.
// Depends on urt_pkg.
module urt_classify #(
    parameter int MAX_FRAGS = 64,
    parameter int IDX_W     = 6
) (
    input  logic [urt_pkg::FIELD_W-1:0]  frag_index,
    input  logic [urt_pkg::FIELD_W-1:0]  frag_count,
    input  logic [urt_pkg::LEN_W-1:0]    body_bytes,
    input  logic [urt_pkg::LEN_W-1:0]    datagram_bytes,
    input  logic [urt_pkg::LEN_W-1:0]    slot_body_bytes,
    output urt_pkg::urt_check_t          check,
    output logic [IDX_W-1:0]             idx,
    output logic [urt_pkg::OFFSET_W-1:0] offset
);
    import urt_pkg::*;

    localparam int PROD_W = IDX_W + LEN_W;

    logic [LEN_W:0]    framed_bytes;
    logic [PROD_W-1:0] product;

    // body plus header must match what actually arrived, and fit its slot
    assign framed_bytes     = {1'b0, body_bytes} + (LEN_W+1)'(HEADER_BYTES);
    assign check.length_bad = (framed_bytes != {1'b0, datagram_bytes})
                              || (body_bytes > slot_body_bytes);
    assign check.range_bad  = (frag_count == '0)
                              || (frag_count > FIELD_W'(MAX_FRAGS))
                              || (frag_index >= frag_count);

    // index is below MAX_FRAGS whenever the range check passes
    assign idx     = frag_index[IDX_W-1:0];
    assign product = PROD_W'(idx) * PROD_W'(slot_body_bytes);
    assign offset  = OFFSET_W'(product);

endmodule

// ===== design/urt_track.sv =====
`timescale 1ns / 1ps
// Frame state: tracked stamp, received bitmap, count and the length/stamp latches.
// Depends on urt_pkg; fed by urt_classify.
module urt_track #(
    parameter int MAX_FRAGS = 64,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  urt_pkg::urt_check_t          check,
    input  logic [IDX_W-1:0]             idx,
    input  logic [urt_pkg::OFFSET_W-1:0] offset,
    input  logic [urt_pkg::STAMP_W-1:0]  frame_stamp,
    input  logic [urt_pkg::FIELD_W-1:0]  frag_index,
    input  logic [urt_pkg::FIELD_W-1:0]  frag_count,
    input  logic [urt_pkg::LEN_W-1:0]    body_bytes,
    output urt_pkg::urt_status_t         status,
    output logic [urt_pkg::OFFSET_W-1:0] write_offset,
    output logic [urt_pkg::LEN_W-1:0]    write_bytes,
    output logic                         frame_done,
    output logic [urt_pkg::OFFSET_W-1:0] frame_length,
    output logic [urt_pkg::STAMP_W-1:0]  done_stamp
);
    import urt_pkg::*;

    logic                 valid_reg,  valid_next;
    logic [STAMP_W-1:0]   stamp_reg,  stamp_next;
    logic [MAX_FRAGS-1:0] map_reg,    map_next;
    logic [CNT_W-1:0]     count_reg,  count_next;
    logic [OFFSET_W-1:0]  length_reg, length_next;
    logic [STAMP_W-1:0]   latch_reg,  latch_next;

    logic                 fresh;
    logic [MAX_FRAGS-1:0] map_eff;
    logic [CNT_W-1:0]     count_eff;
    logic [CNT_W-1:0]     count_inc;
    logic                 dup;
    logic                 last;
    logic                 done;

    assign fresh     = !valid_reg || (stamp_reg != frame_stamp);
    assign map_eff   = fresh ? '0 : map_reg;
    assign count_eff = fresh ? '0 : count_reg;
    assign count_inc = count_eff + CNT_W'(1);
    assign dup       = map_eff[idx];
    assign last      = (frag_index == frag_count - FIELD_W'(1));
    assign done      = (FIELD_W'(count_inc) == frag_count);

    always_comb
    begin
        valid_next   = valid_reg;
        stamp_next   = stamp_reg;
        map_next     = map_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        latch_next   = latch_reg;
        status       = ST_NEW;
        write_offset = '0;
        write_bytes  = '0;
        frame_done   = 1'b0;
        priority if (check.length_bad)
        begin
            status = ST_LEN;
        end
        else if (check.range_bad)
        begin
            status = ST_RANGE;
        end
        else
        begin
            write_offset = offset;
            valid_next   = 1'b1;
            stamp_next   = frame_stamp;
            map_next     = map_eff;
            count_next   = count_eff;
            if (dup)
            begin
                status = ST_DUP;
            end
            else
            begin
                write_bytes = body_bytes;
                if (last)
                begin
                    length_next = offset + OFFSET_W'(body_bytes);
                    latch_next  = frame_stamp;
                end
                map_next   = map_eff | (MAX_FRAGS'(1) << idx);
                count_next = count_inc;
                if (done)
                begin
                    frame_done = 1'b1;
                    valid_next = 1'b0;
                    map_next   = '0;
                    count_next = '0;
                end
            end
        end
    end

    assign frame_length = length_next;
    assign done_stamp   = latch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            stamp_reg  <= '0;
            map_reg    <= '0;
            count_reg  <= '0;
            length_reg <= '0;
            latch_reg  <= '0;
        end
        else if (fire)
        begin
            valid_reg  <= valid_next;
            stamp_reg  <= stamp_next;
            map_reg    <= map_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            latch_reg  <= latch_next;
        end
    end

    // count always mirrors the bitmap population
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(map_reg) == 32'(count_reg))
        else $error("seen count out of step with bitmap");

    // a completed frame is forgotten
    a_done_forgets: assert property (@(posedge clk) disable iff (!rst_n)
        fire && frame_done |=> !valid_reg && (map_reg == '0))
        else $error("frame not cleared after completion");

    // bytes are written and frames finish only for a new fragment
    a_write_only_new: assert property (@(posedge clk) disable iff (!rst_n)
        (write_bytes != '0) || frame_done |-> status == ST_NEW)
        else $error("write or completion on a dropped fragment");

    // an idle bitmap means nothing is tracked
    a_map_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> map_reg == '0)
        else $error("bitmap bits held with no tracked frame");

endmodule

// ===== design/udp_fragment_reassembly_tracker_top.sv =====
`timescale 1ns / 1ps
// Top level of the UDP fragment reassembly tracker.
// Depends on urt_pkg, urt_ifs, urt_classify and urt_track.
//
// Usage:
//   frag   - one parsed fragment header per transaction (valid/ready).
//   result - one result transaction per header: status, payload write offset
//            and length, frame_done, and the latched frame length and stamp.
//   cfg    - write of slot_body_bytes; always ready, write only while idle.
// Path: a taken header waits in the header register, then is checked and loaded
// into the result register, which holds result.valid until result.ready.
// Throughput: one header per cycle while result.ready is high. The header
// register, the combinational checks, bitmap update and 6x16 offset
// multiply, and the result register form the path; frame state updates in
// the cycle a header moves to the result register, so back-to-back headers
// of one frame see each other.
// Reset: the frame is forgotten, latches read zero, slot_body_bytes is 1024.
// Stall: while result.ready is low the result register holds, one more header
// waits in the header register, and frag.ready drops after that.
module udp_fragment_reassembly_tracker_top #(
    parameter int MAX_FRAGS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    urt_frag_if.sink    frag,
    urt_result_if.source result,
    urt_cfg_if.sink     cfg
);
    import urt_pkg::*;

    localparam int IDX_W = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
    localparam int CNT_W = $clog2(MAX_FRAGS + 1);

    // configuration
    logic [LEN_W-1:0] slot_reg;

    // header register
    logic               hdr_valid_reg;
    logic [STAMP_W-1:0] hdr_stamp_reg;
    logic [FIELD_W-1:0] hdr_index_reg;
    logic [FIELD_W-1:0] hdr_count_reg;
    logic [LEN_W-1:0]   hdr_body_reg;
    logic [LEN_W-1:0]   hdr_dgram_reg;

    // result register
    logic                out_valid_reg;
    urt_status_t         out_status_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [LEN_W-1:0]    out_bytes_reg;
    logic                out_done_reg;
    logic [OFFSET_W-1:0] out_length_reg;
    logic [STAMP_W-1:0]  out_stamp_reg;

    logic                advance;
    logic                take;
    urt_check_t          check;
    logic [IDX_W-1:0]    idx;
    logic [OFFSET_W-1:0] offset;
    urt_status_t         status;
    logic [OFFSET_W-1:0] write_offset;
    logic [LEN_W-1:0]    write_bytes;
    logic                frame_done;
    logic [OFFSET_W-1:0] frame_length;
    logic [STAMP_W-1:0]  done_stamp;

    // advance the header when the result register is free or being emptied
    assign advance    = hdr_valid_reg && (!out_valid_reg || result.ready);
    assign frag.ready = !hdr_valid_reg || advance;
    assign take       = frag.valid && frag.ready;
    assign cfg.ready  = 1'b1;

    urt_classify #(
        .MAX_FRAGS (MAX_FRAGS),
        .IDX_W     (IDX_W)
    ) u_classify (
        .frag_index      (hdr_index_reg),
        .frag_count      (hdr_count_reg),
        .body_bytes      (hdr_body_reg),
        .datagram_bytes  (hdr_dgram_reg),
        .slot_body_bytes (slot_reg),
        .check           (check),
        .idx             (idx),
        .offset          (offset)
    );

    urt_track #(
        .MAX_FRAGS (MAX_FRAGS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (advance),
        .check        (check),
        .idx          (idx),
        .offset       (offset),
        .frame_stamp  (hdr_stamp_reg),
        .frag_index   (hdr_index_reg),
        .frag_count   (hdr_count_reg),
        .body_bytes   (hdr_body_reg),
        .status       (status),
        .write_offset (write_offset),
        .write_bytes  (write_bytes),
        .frame_done   (frame_done),
        .frame_length (frame_length),
        .done_stamp   (done_stamp)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= SLOT_RESET;
            hdr_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                slot_reg <= cfg.data;
            end
            if (take)
            begin
                hdr_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                hdr_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: load on transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hdr_stamp_reg <= frag.frame_stamp;
            hdr_index_reg <= frag.frag_index;
            hdr_count_reg <= frag.frag_count;
            hdr_body_reg  <= frag.body_bytes;
            hdr_dgram_reg <= frag.datagram_bytes;
        end
        if (advance)
        begin
            out_status_reg <= status;
            out_offset_reg <= write_offset;
            out_bytes_reg  <= write_bytes;
            out_done_reg   <= frame_done;
            out_length_reg <= frame_length;
            out_stamp_reg  <= done_stamp;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.write_offset = out_offset_reg;
    assign result.write_bytes  = out_bytes_reg;
    assign result.frame_done   = out_done_reg;
    assign result.frame_length = out_length_reg;
    assign result.done_stamp   = out_stamp_reg;

    // a waiting header never overtakes: it moves only into a free result slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !advance)
        else $error("result overwritten while stalled");

    // a header is taken only when the header register is free or moving on
    a_hdr_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        take && hdr_valid_reg |-> advance)
        else $error("header register overwritten");

    // every advanced header shows up as a result on the next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced header produced no result");

endmodule
